### sv/svrt_pkg.sv
// ----------------------------------------------------------------------------
// Slab volume ray test package
// Shared constants and the types that travel between the front part, the
// divider and the back part of the slab test.
// ----------------------------------------------------------------------------
`default_nettype none
package svrt_pkg;
	localparam int unsigned NumPlanesDefault = 7;
	localparam int unsigned QW = 32;
	// Dividend is (extent - numerator) * 2^16, at most 49 bits magnitude.
	localparam int unsigned DW = 49;
	localparam int unsigned DivSteps = DW;
	localparam logic signed [QW-1:0] QMax = 32'sh7FFF_FFFF;
	localparam logic signed [QW-1:0] QMin = 32'sh8000_0000;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [1:0] {
		ZK_NORMAL = 2'd0,
		ZK_POS    = 2'd1,
		ZK_NEG    = 2'd2,
		ZK_NONE   = 2'd3
	} zkind_t;

	// Classified slab as handed from the front part to the back part.
	typedef struct packed {
		logic [2:0]          plane_index;
		logic                last_plane;
		logic                in_range;
		logic                den_neg;
		logic                den_zero;
		zkind_t              kind_n;
		zkind_t              kind_f;
		logic                neg_n;
		logic                neg_f;
		logic [DW-1:0]       mag_n;
		logic [DW-1:0]       mag_f;
		logic [QW-1:0]       den_mag;
		logic signed [QW-1:0] max_distance;
	} slab_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_OUT  = 2'd2
	} bstate_t;
endpackage
`default_nettype wire

### sv/slab_volume_ray_test.sv
// ----------------------------------------------------------------------------
// Slab volume ray test.
// Input channel: a queue interface, push/full. One transfer carries one
// slab: plane_index, last_plane, the two dot products, two extents and
// max_distance. plane_index zero restarts the running interval.
// Result channel: empty/pop. A result appears only for a slab with
// last_plane set; it holds hit, the interval bounds, entry plane and
// worth_testing, and stays until popped.
// A two-entry queue parts the front part from the back part, so slabs are
// taken while the back part works. The back part runs two serial
// divisions of 49 quotient bits each through one shared divider, and
// takes no new slab until both are done and the result is formed.
// While a result waits unpopped the back part takes no further slab,
// and full rises once the queue fills.
// Reset empties the queue, drops any waiting result and resets the
// interval to its widest value.
// ----------------------------------------------------------------------------
`default_nettype none
module slab_volume_ray_test #(
	parameter int unsigned NUM_PLANES = svrt_pkg::NumPlanesDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [2:0]          plane_index,
	input  wire logic                last_plane,
	input  wire logic signed [31:0]  numerator,
	input  wire logic signed [31:0]  denominator,
	input  wire logic signed [31:0]  extent_near,
	input  wire logic signed [31:0]  extent_far,
	input  wire logic signed [31:0]  max_distance,
	output logic                     empty,
	input  wire logic                pop,
	output logic                     hit,
	output logic signed [31:0]       near_distance,
	output logic signed [31:0]       far_distance,
	output logic [2:0]               entry_plane,
	output logic                     worth_testing
);
	logic            q_valid, q_take;
	svrt_pkg::slab_t q_data;

	svrt_front #(.NUM_PLANES(NUM_PLANES)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.plane_index(plane_index), .last_plane(last_plane),
		.numerator(numerator), .denominator(denominator),
		.extent_near(extent_near), .extent_far(extent_far),
		.max_distance(max_distance),
		.q_valid(q_valid), .q_take(q_take), .q_data(q_data)
	);

	svrt_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_data(q_data), .empty(empty), .pop(pop), .hit(hit),
		.near_distance(near_distance), .far_distance(far_distance),
		.entry_plane(entry_plane), .worth_testing(worth_testing)
	);
endmodule
`default_nettype wire

### sv/svrt_front.sv
// ----------------------------------------------------------------------------
// Slab front part
// Forms the exact differences, their magnitudes and signs, classifies the
// zero-denominator cases, and queues the slab for the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module svrt_front #(
	parameter int unsigned NUM_PLANES = svrt_pkg::NumPlanesDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [2:0]          plane_index,
	input  wire logic                last_plane,
	input  wire logic signed [31:0]  numerator,
	input  wire logic signed [31:0]  denominator,
	input  wire logic signed [31:0]  extent_near,
	input  wire logic signed [31:0]  extent_far,
	input  wire logic signed [31:0]  max_distance,
	output logic                     q_valid,
	input  wire logic                q_take,
	output svrt_pkg::slab_t          q_data
);
	localparam int unsigned Depth = svrt_pkg::QueueDepth;

	svrt_pkg::slab_t mem_q [Depth];
	logic            wptr_q, rptr_q;
	logic [1:0]      count_q;
	svrt_pkg::slab_t cls;
	logic signed [32:0] dn, df;
	logic [32:0] an, af;
	logic do_push, do_pop;

	always_comb begin
		dn = 33'(extent_near) - 33'(numerator);
		df = 33'(extent_far) - 33'(numerator);
		an = dn[32] ? 33'(-dn) : dn;
		af = df[32] ? 33'(-df) : df;
		cls.plane_index = plane_index;
		cls.last_plane = last_plane;
		cls.in_range = 32'(plane_index) < NUM_PLANES;
		cls.den_neg = denominator[31];
		cls.den_zero = denominator == '0;
		cls.neg_n = dn[32] ^ denominator[31];
		cls.neg_f = df[32] ^ denominator[31];
		cls.mag_n = {an, 16'h0};
		cls.mag_f = {af, 16'h0};
		cls.den_mag = denominator[31] ? 32'(-denominator) : denominator;
		cls.max_distance = max_distance;
		if (denominator != '0) begin
			cls.kind_n = svrt_pkg::ZK_NORMAL;
			cls.kind_f = svrt_pkg::ZK_NORMAL;
		end else begin
			cls.kind_n = (dn == '0) ? svrt_pkg::ZK_NONE :
				(dn[32] ? svrt_pkg::ZK_NEG : svrt_pkg::ZK_POS);
			cls.kind_f = (df == '0) ? svrt_pkg::ZK_NONE :
				(df[32] ? svrt_pkg::ZK_NEG : svrt_pkg::ZK_POS);
		end
	end

	assign full    = count_q == 2'(Depth);
	assign q_valid = count_q != '0;
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= cls;
		end
	end
	assign q_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) count_q <= 2'(Depth);
	endproperty
	assert property (p_no_overflow) else $error("front queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 2'd1)
		else $error("front queue count lost a transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !do_pop) else $error("pop from empty front queue");
endmodule
`default_nettype wire

### sv/svrt_div.sv
// ----------------------------------------------------------------------------
// Slab divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module svrt_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [svrt_pkg::DW-1:0]       dividend,
	input  wire logic [svrt_pkg::QW-1:0]       divisor,
	output logic                               done,
	output logic [svrt_pkg::DW-1:0]            quotient
);
	localparam int unsigned DW = svrt_pkg::DW;
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [svrt_pkg::QW:0] rem_q;
	logic [svrt_pkg::QW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [svrt_pkg::QW:0] trial;
	logic [svrt_pkg::QW+1:0] diff;

	always_comb begin
		trial = {rem_q[svrt_pkg::QW-1:0], quo_q[DW-1]};
		diff = {1'b0, trial} - {2'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[svrt_pkg::QW+1]) begin
				rem_q <= diff[svrt_pkg::QW:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end
	assign quotient = quo_q;
endmodule
`default_nettype wire

### sv/svrt_back.sv
// ----------------------------------------------------------------------------
// Slab back part
// Divides both extents, saturates, swaps, updates the running interval and
// holds the result for the output side.
// ----------------------------------------------------------------------------
`default_nettype none
module svrt_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	output logic                      q_take,
	input  wire svrt_pkg::slab_t      q_data,
	output logic                      empty,
	input  wire logic                 pop,
	output logic                      hit,
	output logic signed [31:0]        near_distance,
	output logic signed [31:0]        far_distance,
	output logic [2:0]                entry_plane,
	output logic                      worth_testing
);
	localparam int unsigned DW = svrt_pkg::DW;

	svrt_pkg::bstate_t state_q, state_d;
	svrt_pkg::slab_t   cur_q;
	logic              second_q;
	logic signed [31:0] tn_q, near_q, far_q;
	logic signed [31:0] tf_q;
	logic [2:0]        entry_q;
	logic              missed_q, out_full_q;
	logic              div_start, div_done;
	logic [DW-1:0]     div_quo;
	logic [DW-1:0]     div_dividend;
	logic [svrt_pkg::QW-1:0] div_divisor;
	logic signed [31:0] sat_t, tf;
	logic              take, finish;
	logic signed [31:0] nb, fb, tn_s, tf_s, near_n, far_n;
	logic [2:0]        ent_b, ent_n;
	logic              vn_s, vf_s, vn, vf, miss_b, miss_n;

	// The first division starts in the cycle the slab is taken, before cur_q
	// holds it; the second one always works on the far extent.
	assign div_dividend = take ? q_data.mag_n : cur_q.mag_f;
	assign div_divisor  = take ? q_data.den_mag : cur_q.den_mag;

	svrt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quo)
	);

	function automatic logic signed [31:0] sat(input logic neg,
		input logic [DW-1:0] m);
		logic big;
		begin
			big = neg ? (m > DW'(32'h8000_0000)) : (m > DW'(32'h7FFF_FFFF));
			if (big) sat = neg ? svrt_pkg::QMin : svrt_pkg::QMax;
			else sat = neg ? 32'(-m) : m[31:0];
		end
	endfunction

	function automatic logic signed [31:0] zval(input svrt_pkg::zkind_t k,
		input logic signed [31:0] t);
		begin
			case (k)
				svrt_pkg::ZK_POS: zval = svrt_pkg::QMax;
				svrt_pkg::ZK_NEG: zval = svrt_pkg::QMin;
				default: zval = t;
			endcase
		end
	endfunction

	assign sat_t = sat(second_q ? cur_q.neg_f : cur_q.neg_n, div_quo);
	assign take = state_q == svrt_pkg::BK_IDLE && q_valid && !out_full_q;
	assign q_take = take;

	always_comb begin
		state_d = state_q;
		case (state_q)
			svrt_pkg::BK_IDLE: if (take) state_d = svrt_pkg::BK_DIV;
			svrt_pkg::BK_DIV: if (div_done && second_q) state_d = svrt_pkg::BK_OUT;
			svrt_pkg::BK_OUT: state_d = svrt_pkg::BK_IDLE;
			default: state_d = svrt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		finish = 1'b0;
		case (state_q)
			svrt_pkg::BK_IDLE: div_start = take;
			svrt_pkg::BK_DIV: div_start = div_done && !second_q;
			svrt_pkg::BK_OUT: finish = 1'b1;
			default: ;
		endcase
	end

	// Final quotient of the far extent.
	assign tf = sat_t;

	always_comb begin
		logic signed [31:0] a, b;
		logic va, vb;
		a = zval(cur_q.kind_n, tn_q);
		b = zval(cur_q.kind_f, tf_q);
		va = cur_q.kind_n != svrt_pkg::ZK_NONE;
		vb = cur_q.kind_f != svrt_pkg::ZK_NONE;
		if (cur_q.plane_index == 3'd0) begin
			nb = svrt_pkg::QMin; fb = svrt_pkg::QMax; ent_b = 3'd0; miss_b = 1'b0;
		end else begin
			nb = near_q; fb = far_q; ent_b = entry_q; miss_b = missed_q;
		end
		if (cur_q.den_neg) begin
			tn_s = b; tf_s = a; vn_s = vb; vf_s = va;
		end else begin
			tn_s = a; tf_s = b; vn_s = va; vf_s = vb;
		end
		vn = vn_s; vf = vf_s;
		near_n = nb; far_n = fb; ent_n = ent_b; miss_n = miss_b;
		if (!miss_b && cur_q.in_range) begin
			if (vn && tn_s > nb) begin
				near_n = tn_s; ent_n = cur_q.plane_index;
			end
			if (vf && tf_s < fb) far_n = tf_s;
			if (near_n > far_n) miss_n = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= q_data;
		if (div_done && !second_q) tn_q <= sat_t;
		if (div_done && second_q) tf_q <= tf;
		if (finish && cur_q.last_plane) begin
			hit <= !miss_n;
			near_distance <= near_n;
			far_distance <= far_n;
			entry_plane <= ent_n;
			worth_testing <= !miss_n && (near_n < cur_q.max_distance);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svrt_pkg::BK_IDLE;
			second_q <= 1'b0;
			near_q <= svrt_pkg::QMin;
			far_q <= svrt_pkg::QMax;
			entry_q <= 3'd0;
			missed_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) second_q <= 1'b0;
			else if (div_done && !second_q) second_q <= 1'b1;
			if (finish) begin
				near_q <= near_n; far_q <= far_n;
				entry_q <= ent_n; missed_q <= miss_n;
			end
			if (finish && cur_q.last_plane) out_full_q <= 1'b1;
			else if (pop && out_full_q) out_full_q <= 1'b0;
		end
	end
	assign empty = !out_full_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		missed_q && finish && cur_q.plane_index != 3'd0 |=> missed_q)
		else $error("sticky miss cleared without restart");
	assert property (@(posedge clk) disable iff (!arst_n)
		!missed_q |-> near_q <= far_q) else $error("empty interval not flagged");
	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> state_q == svrt_pkg::BK_IDLE && !out_full_q)
		else $error("slab taken while busy");
endmodule
`default_nettype wire

### test/slab_volume_ray_test_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab volume ray test checker
// Watches the slab and result channels of the ray test, keeps its own
// running interval per transfer and compares each popped result field by
// field against the oldest predicted one.
// ----------------------------------------------------------------------------
module slab_volume_ray_test_checker #(
	parameter int unsigned NUM_PLANES = svrt_pkg::NumPlanesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [2:0]         plane_index,
	input  logic               last_plane,
	input  logic signed [31:0] numerator,
	input  logic signed [31:0] denominator,
	input  logic signed [31:0] extent_near,
	input  logic signed [31:0] extent_far,
	input  logic signed [31:0] max_distance,
	input  logic               empty,
	input  logic               pop,
	input  logic               hit,
	input  logic signed [31:0] near_distance,
	input  logic signed [31:0] far_distance,
	input  logic [2:0]         entry_plane,
	input  logic               worth_testing,
	output int                 errors,
	output int                 outstanding
);
	localparam logic signed [31:0] QMax = svrt_pkg::QMax;
	localparam logic signed [31:0] QMin = svrt_pkg::QMin;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] near_d;
		logic signed [31:0] far_d;
		logic [2:0]         entry;
		logic               worth;
	} verdict_t;

	verdict_t verdicts[$];

	logic signed [31:0] interval_lo;
	logic signed [31:0] interval_hi;
	logic [2:0]         entry_slab;
	logic               missed;

	// Crossing parameter (ext - num) / den in Q16.16, saturated. ok is low
	// for zero over zero, which leaves the bound alone.
	function automatic logic signed [31:0] crossing(input logic signed [31:0] ext,
			input logic signed [31:0] num, input logic signed [31:0] den,
			output logic ok);
		longint diff;
		longint q;
		diff = longint'(ext) - longint'(num);
		ok = 1'b1;
		if (den == 0) begin
			if (diff > 0) return QMax;
			if (diff < 0) return QMin;
			ok = 1'b0;
			return '0;
		end
		q = (diff * 65536) / longint'(den);
		if (q > longint'(QMax)) q = longint'(QMax);
		if (q < longint'(QMin)) q = longint'(QMin);
		return q[31:0];
	endfunction

	task automatic narrow_interval();
		logic signed [31:0] tn, tf, t;
		logic on, of, o;
		if (plane_index == 0) begin
			interval_lo = QMin;
			interval_hi = QMax;
			entry_slab = '0;
			missed = 1'b0;
		end
		if (!missed && plane_index < NUM_PLANES) begin
			tn = crossing(extent_near, numerator, denominator, on);
			tf = crossing(extent_far, numerator, denominator, of);
			if (denominator < 0) begin
				t = tn; tn = tf; tf = t;
				o = on; on = of; of = o;
			end
			if (on && tn > interval_lo) begin
				interval_lo = tn;
				entry_slab = plane_index;
			end
			if (of && tf < interval_hi) interval_hi = tf;
			if (interval_lo > interval_hi) missed = 1'b1;
		end
		if (last_plane)
			verdicts.push_back('{hit: !missed, near_d: interval_lo, far_d: interval_hi,
				entry: entry_slab, worth: !missed && interval_lo < max_distance});
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			interval_lo = QMin;
			interval_hi = QMax;
			entry_slab = '0;
			missed = 1'b0;
			verdicts.delete();
			errors = 0;
		end else begin
			if (push && !full) narrow_interval();
			if (pop && !empty) begin
				if (verdicts.size() == 0) begin
					$display("%0t: result with none expected", $time);
					errors++;
				end else begin
					want = verdicts.pop_front();
					if (hit !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
						errors++;
					end
					if (near_distance !== want.near_d) begin
						$display("%0t: near_distance expected %h actual %h", $time,
							want.near_d, near_distance);
						errors++;
					end
					if (far_distance !== want.far_d) begin
						$display("%0t: far_distance expected %h actual %h", $time,
							want.far_d, far_distance);
						errors++;
					end
					if (entry_plane !== want.entry) begin
						$display("%0t: entry_plane expected %0d actual %0d", $time,
							want.entry, entry_plane);
						errors++;
					end
					if (worth_testing !== want.worth) begin
						$display("%0t: worth_testing expected %0b actual %0b", $time,
							want.worth, worth_testing);
						errors++;
					end
				end
			end
		end
		outstanding = verdicts.size();
	end
endmodule

### test/slab_volume_ray_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab volume ray test testbench
// Streams directed and random slabs, mostly whole volumes with small values
// so intervals stay open, with noise and broken volumes mixed in, and pops
// results under random stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module slab_volume_ray_test_test;
	localparam int NumPlanes = svrt_pkg::NumPlanesDefault;
	localparam logic signed [31:0] QMax = svrt_pkg::QMax;
	localparam logic signed [31:0] QMin = svrt_pkg::QMin;
	localparam int RandomSlabs = 1400;
	localparam int StallLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [2:0] plane_index = '0;
	logic last_plane = 1'b0;
	logic signed [31:0] numerator = '0, denominator = '0;
	logic signed [31:0] extent_near = '0, extent_far = '0, max_distance = '0;
	logic hit, worth_testing;
	logic signed [31:0] near_distance, far_distance;
	logic [2:0] entry_plane;
	int errors, outstanding;
	int quiet_cycles = 0;
	logic calm = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	slab_volume_ray_test dut (.*);
	slab_volume_ray_test_checker checker_i (.*);

	// Result side stalls at random except during the calm stretch.
	always @(negedge clk) pop = calm || $urandom_range(99) >= 32;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("slab_volume_ray_test_test: FAIL");
			$finish;
		end
	end

	task automatic send(input logic [2:0] idx, input logic lst,
			input logic signed [31:0] num, input logic signed [31:0] den,
			input logic signed [31:0] en, input logic signed [31:0] ef,
			input logic signed [31:0] maxd);
		while (!calm && $urandom_range(99) < 32) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		plane_index = idx;
		last_plane = lst;
		numerator = num;
		denominator = den;
		extent_near = en;
		extent_far = ef;
		max_distance = maxd;
		do @(posedge clk); while (full);
		@(negedge clk);
		push = 1'b0;
	endtask

	function automatic logic signed [31:0] any_q();
		case ($urandom_range(5))
			0: return QMin;
			1: return QMax;
			2: return 32'sd0;
			3: return $urandom_range(1) ? 32'sd65536 : -32'sd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] near_q(input int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	initial begin
		int n, sent;
		logic signed [31:0] num, den, half, maxd;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Saturating quotients, both signs of denominator.
		send(0, 0, QMin, 32'sd1, QMax, QMax, 0);
		send(1, 1, QMax, -32'sd1, QMin, QMax, QMax);
		// Zero denominator: positive, negative and zero over zero.
		send(0, 0, 32'sd100, 32'sd0, 32'sd100, 32'sd200, 0);
		send(1, 0, 32'sd100, 32'sd0, 32'sd50, 32'sd100, 0);
		send(2, 1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, QMin);
		// An ordinary hit followed by a sticky miss.
		send(0, 0, 32'sd0, 32'sd65536, -32'sd65536, 32'sd65536, 0);
		send(1, 1, 32'sd0, -32'sd65536, -32'sd131072, 32'sd131072, 32'sd196608);
		send(0, 0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd131072, 0);
		send(1, 0, 32'sd0, 32'sd65536, -32'sd262144, -32'sd196608, 0);
		send(2, 0, 32'sd0, 32'sd65536, -32'sd65536, 32'sd655360, 0);
		send(3, 1, QMin, QMin, QMax, QMax, QMax);
		// Out-of-range index with a result, then a continuation with no restart.
		send(7, 1, QMax, QMin, QMin, QMax, QMin);
		send(3, 1, 32'sd5, -32'sd3, 32'sd77, -32'sd9, QMax);
		send(6, 1, -32'sd1, 32'sd1, QMax, QMin, -32'sd1);

		sent = 0;
		while (sent < RandomSlabs) begin
			calm = sent >= 600 && sent < 800;
			if ($urandom_range(9) < 8) begin
				// A whole volume with a likely nonempty interval.
				n = $urandom_range(NumPlanes, 1);
				num = near_q(1 << 20);
				maxd = $urandom_range(3) == 0 ? any_q() : near_q(1 << 22);
				for (int i = 0; i < n; i++) begin
					den = $urandom_range(15) == 0 ? 32'sd0 : near_q(1 << 18);
					half = $urandom_range(1 << 21);
					send(3'(i), i == n - 1, num, den, num - half - near_q(1 << 14),
						num + half + near_q(1 << 14), maxd);
				end
				sent += n;
			end else begin
				send(3'($urandom), $urandom_range(2) == 0, any_q(),
					$urandom_range(7) == 0 ? 32'sd0 : any_q(), any_q(), any_q(), any_q());
				sent++;
			end
		end
		calm = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("slab_volume_ray_test_test: PASS");
		else
			$display("slab_volume_ray_test_test: FAIL");
		$finish;
	end
endmodule
